// File: rtl/mosa_pkg.sv
// ----------------------------------------------------------------------------
// mosa_pkg
// Operation and status codes shared by the median block and its ports.
// ----------------------------------------------------------------------------
package mosa_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_CLEAR        = 2'd0;
    localparam t_op OP_APPEND_FIRST = 2'd1;
    localparam t_op OP_APPEND_SECOND = 2'd2;
    localparam t_op OP_MEDIAN       = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EMPTY     = 2'd1;
    localparam t_status ST_EXHAUSTED = 2'd2;
    localparam t_status ST_DROPPED   = 2'd3;

endpackage

// File: rtl/mosa_store.sv
// ----------------------------------------------------------------------------
// mosa_store
// Single-port-write, single-port-read element store with registered read data.
// ----------------------------------------------------------------------------
module mosa_store #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_WIDTH = 10
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [ADDR_WIDTH-1:0] i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic [ADDR_WIDTH-1:0] i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/median_of_two_sorted_arrays_top.sv
// ----------------------------------------------------------------------------
// median_of_two_sorted_arrays_top
// Loads two ascending arrays into on-chip stores and finds twice the combined
// median by a binary search over the partitions of the shorter array.
//
//   Channel  Direction  Handshake                 Word
//   in       sink       i_in_valid / o_in_stall   i_operation, i_value
//   out      source     o_out_valid / i_out_stall o_twice_median, o_status
//
// Appends are taken back to back. A median request runs at most
// clog2(DEPTH+2) search steps; each step reads both neighbors of a partition
// through the single read port of each store. A request that fails early
// skips the search. Reset empties both arrays and clears the dropped flag.
// The input is stalled while a median is computed; a finished result waits
// in the output register.
// ----------------------------------------------------------------------------
module median_of_two_sorted_arrays_top #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  mosa_pkg::t_op          i_operation,
    input  logic signed [31:0]     i_value,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic signed [32:0]     o_twice_median,
    output mosa_pkg::t_status      o_status
);

    import mosa_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VB   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int SUMW = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PART   = 4'd1;
    localparam logic [3:0] S_RDL    = 4'd2;
    localparam logic [3:0] S_RDR    = 4'd3;
    localparam logic [3:0] S_CAPR   = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_SUM    = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    localparam logic signed [DATA_WIDTH-1:0] LOWEST  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] HIGHEST = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic [3:0]                   r_state, n_state;
    logic [CW-1:0]                r_first_count, n_first_count;
    logic [CW-1:0]                r_second_count, n_second_count;
    logic                         r_dropped, n_dropped;
    logic                         r_out_valid, n_out_valid;
    logic signed [32:0]           r_out_twice, n_out_twice;
    t_status                      r_out_status, n_out_status;

    logic                         r_swap, n_swap;
    logic                         r_odd, n_odd;
    logic [CW-1:0]                r_x, n_x;
    logic [CW-1:0]                r_y, n_y;
    logic [CW-1:0]                r_half, n_half;
    logic signed [CW:0]           r_lo, n_lo;
    logic signed [CW:0]           r_hi, n_hi;
    logic [CW-1:0]                r_px, n_px;
    logic [CW-1:0]                r_py, n_py;
    logic signed [DATA_WIDTH-1:0] r_max_x, n_max_x;
    logic signed [DATA_WIDTH-1:0] r_max_y, n_max_y;
    logic signed [DATA_WIDTH-1:0] r_min_x, n_min_x;
    logic signed [DATA_WIDTH-1:0] r_min_y, n_min_y;
    logic signed [DATA_WIDTH-1:0] r_left, n_left;
    logic signed [DATA_WIDTH-1:0] r_right, n_right;
    logic signed [32:0]           r_res_twice, n_res_twice;
    t_status                      r_res_status, n_res_status;

    logic                         w_accept;
    logic signed [VB-1:0]         w_value_trunc;
    logic [DATA_WIDTH-1:0]        w_value;
    logic                         w_first_full;
    logic                         w_second_full;
    logic                         w_wr_first;
    logic                         w_wr_second;
    logic [CW-1:0]                w_a_idx;
    logic [CW-1:0]                w_b_idx;
    logic [AW-1:0]                w_first_rd_addr;
    logic [AW-1:0]                w_second_rd_addr;
    logic [DATA_WIDTH-1:0]        w_first_rd_data;
    logic [DATA_WIDTH-1:0]        w_second_rd_data;
    logic signed [DATA_WIDTH-1:0] w_a_data;
    logic signed [DATA_WIDTH-1:0] w_b_data;
    logic [CW:0]                  w_total;
    logic [CW:0]                  w_mid_sum;
    logic                         w_left_ok;
    logic                         w_right_ok;
    logic signed [SUMW-1:0]       w_left_ext;
    logic signed [SUMW-1:0]       w_right_ext;
    logic signed [SUMW-1:0]       w_sum;

    assign o_in_stall     = (r_state != S_IDLE);
    assign w_accept       = i_in_valid && !o_in_stall;
    assign w_value_trunc  = i_value[VB-1:0];
    assign w_value        = DATA_WIDTH'(w_value_trunc);
    assign w_first_full   = (r_first_count == CW'(DEPTH));
    assign w_second_full  = (r_second_count == CW'(DEPTH));
    assign w_wr_first     = w_accept && (i_operation == OP_APPEND_FIRST) && !w_first_full;
    assign w_wr_second    = w_accept && (i_operation == OP_APPEND_SECOND) && !w_second_full;

    assign w_a_idx          = (r_state == S_RDL) ? (r_px - CW'(1)) : r_px;
    assign w_b_idx          = (r_state == S_RDL) ? (r_py - CW'(1)) : r_py;
    assign w_first_rd_addr  = r_swap ? w_b_idx[AW-1:0] : w_a_idx[AW-1:0];
    assign w_second_rd_addr = r_swap ? w_a_idx[AW-1:0] : w_b_idx[AW-1:0];
    assign w_a_data         = r_swap ? w_second_rd_data : w_first_rd_data;
    assign w_b_data         = r_swap ? w_first_rd_data : w_second_rd_data;

    assign w_total    = {1'b0, r_first_count} + {1'b0, r_second_count};
    assign w_mid_sum  = {1'b0, r_lo[CW-1:0]} + {1'b0, r_hi[CW-1:0]};
    assign w_left_ok  = (r_max_x <= r_min_y);
    assign w_right_ok = (r_max_y <= r_min_x);
    assign w_left_ext = SUMW'(r_left);
    assign w_right_ext = SUMW'(r_right);
    assign w_sum      = w_left_ext + (r_odd ? w_left_ext : w_right_ext);

    mosa_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_WIDTH (AW)
    ) u_first_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_first),
        .i_wr_addr (r_first_count[AW-1:0]),
        .i_wr_data (w_value),
        .i_rd_addr (w_first_rd_addr),
        .o_rd_data (w_first_rd_data)
    );

    mosa_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_WIDTH (AW)
    ) u_second_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_second),
        .i_wr_addr (r_second_count[AW-1:0]),
        .i_wr_data (w_value),
        .i_rd_addr (w_second_rd_addr),
        .o_rd_data (w_second_rd_data)
    );

    always_comb begin
        n_state        = r_state;
        n_first_count  = r_first_count;
        n_second_count = r_second_count;
        n_dropped      = r_dropped;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_twice    = r_out_twice;
        n_out_status   = r_out_status;
        n_swap         = r_swap;
        n_odd          = r_odd;
        n_x            = r_x;
        n_y            = r_y;
        n_half         = r_half;
        n_lo           = r_lo;
        n_hi           = r_hi;
        n_px           = r_px;
        n_py           = r_py;
        n_max_x        = r_max_x;
        n_max_y        = r_max_y;
        n_min_x        = r_min_x;
        n_min_y        = r_min_y;
        n_left         = r_left;
        n_right        = r_right;
        n_res_twice    = r_res_twice;
        n_res_status   = r_res_status;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_operation)
                        OP_CLEAR: begin
                            n_first_count  = '0;
                            n_second_count = '0;
                            n_dropped      = 1'b0;
                        end
                        OP_APPEND_FIRST: begin
                            if (w_first_full) begin
                                n_dropped = 1'b1;
                            end else begin
                                n_first_count = r_first_count + CW'(1);
                            end
                        end
                        OP_APPEND_SECOND: begin
                            if (w_second_full) begin
                                n_dropped = 1'b1;
                            end else begin
                                n_second_count = r_second_count + CW'(1);
                            end
                        end
                        default: begin
                            n_res_twice = '0;
                            if (r_dropped) begin
                                n_res_status = ST_DROPPED;
                                n_state      = S_DONE;
                            end else if (w_total == '0) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                n_swap  = (r_first_count > r_second_count);
                                n_x     = n_swap ? r_second_count : r_first_count;
                                n_y     = n_swap ? r_first_count : r_second_count;
                                n_half  = CW'((w_total + (CW+1)'(1)) >> 1);
                                n_odd   = w_total[0];
                                n_lo    = '0;
                                n_hi    = {1'b0, n_x};
                                n_state = S_PART;
                            end
                        end
                    endcase
                end
            end
            S_PART: begin
                if (r_lo > r_hi) begin
                    n_res_twice  = '0;
                    n_res_status = ST_EXHAUSTED;
                    n_state      = S_DONE;
                end else begin
                    n_px    = w_mid_sum[CW:1];
                    n_py    = r_half - w_mid_sum[CW:1];
                    n_state = S_RDL;
                end
            end
            S_RDL: begin
                n_state = S_RDR;
            end
            S_RDR: begin
                n_max_x = (r_px == '0) ? LOWEST : w_a_data;
                n_max_y = (r_py == '0) ? LOWEST : w_b_data;
                n_state = S_CAPR;
            end
            S_CAPR: begin
                n_min_x = (r_px == r_x) ? HIGHEST : w_a_data;
                n_min_y = (r_py >= r_y) ? HIGHEST : w_b_data;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (w_left_ok && w_right_ok) begin
                    n_left  = (r_max_x > r_max_y) ? r_max_x : r_max_y;
                    n_right = (r_min_x < r_min_y) ? r_min_x : r_min_y;
                    n_state = S_SUM;
                end else if (!w_left_ok) begin
                    n_hi    = $signed({1'b0, r_px}) - (CW+1)'(1);
                    n_state = S_PART;
                end else begin
                    n_lo    = $signed({1'b0, r_px}) + (CW+1)'(1);
                    n_state = S_PART;
                end
            end
            S_SUM: begin
                n_res_twice  = w_sum[32:0];
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_twice  = r_res_twice;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_first_count  <= '0;
            r_second_count <= '0;
            r_dropped      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_first_count  <= n_first_count;
            r_second_count <= n_second_count;
            r_dropped      <= n_dropped;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_twice  <= n_out_twice;
        r_out_status <= n_out_status;
        r_swap       <= n_swap;
        r_odd        <= n_odd;
        r_x          <= n_x;
        r_y          <= n_y;
        r_half       <= n_half;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_px         <= n_px;
        r_py         <= n_py;
        r_max_x      <= n_max_x;
        r_max_y      <= n_max_y;
        r_min_x      <= n_min_x;
        r_min_y      <= n_min_y;
        r_left       <= n_left;
        r_right      <= n_right;
        r_res_twice  <= n_res_twice;
        r_res_status <= n_res_status;
    end

    assign o_out_valid    = r_out_valid;
    assign o_twice_median = r_out_twice;
    assign o_status       = r_out_status;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_twice_median == '0))
        else $error("Failed request carries a nonzero median.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_first_count <= CW'(DEPTH)) && (r_second_count <= CW'(DEPTH)))
        else $error("Element count exceeds the store depth.");

    a_median_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_operation == OP_MEDIAN) |=> o_in_stall)
        else $error("Input taken while a median request is in progress.");

    a_partition_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDL) |-> (r_px <= r_x) && (r_py <= r_y))
        else $error("Partition index outside the array.");

endmodule
